@@ hw/rtl/shader_issue_hazard_checker_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef SHADER_ISSUE_HAZARD_CHECKER_MACROS_SVH
`define SHADER_ISSUE_HAZARD_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

`define SIH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hazard checker assertion failed");

`define SIH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hazard checker assertion failed");

`define SIH_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hazard checker assertion failed");

`else

`define SIH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define SIH_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ hw/rtl/sih_pkg.sv @@
`default_nettype none

package sih_pkg;

    localparam int NUM_REGS   = 256;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int LIMIT_W    = REG_IDX_W + 1;
    localparam int CYCLE_BITS = 32;
    localparam int NUM_SRC    = 3;
    localparam int MAX_DST    = 4;
    localparam int DST_CNT_W  = 3;
    localparam int BANKS      = MAX_DST;
    localparam int BANK_W     = $clog2(BANKS);
    localparam int BANK_DEPTH = NUM_REGS / BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(NUM_REGS);

    // instruction kinds
    localparam logic [2:0] KIND_FLOW = 3'd0;
    localparam logic [2:0] KIND_ALU3 = 3'd3;
    localparam logic [2:0] KIND_SFU  = 3'd4;
    localparam logic [2:0] KIND_TEX  = 3'd5;

    // writer kinds
    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_ALU  = 2'd1;
    localparam logic [1:0] WK_SFU  = 2'd2;
    localparam logic [1:0] WK_TEX  = 2'd3;

    localparam int SLOTS_LONG  = 6;
    localparam int SLOTS_STD   = 3;
    localparam int SLOTS_SHORT = 1;
    localparam int SLOT_SHORT_SRC = 2;

    typedef logic [REG_IDX_W-1:0]  reg_idx_t;
    typedef logic [CYCLE_BITS-1:0] cycle_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 is_end;
        logic                 is_varying;
        logic                 end_input;
        logic                 sync_ss;
        logic                 sync_sy;
        logic [NUM_SRC-1:0]   src_mask;
        reg_idx_t             src_a;
        reg_idx_t             src_b;
        reg_idx_t             src_c;
        reg_idx_t             dst_base;
        logic [DST_CNT_W-1:0] dst_count;
    } sih_item_t;

    typedef struct packed {
        cycle_t cycle_now;
        logic   first_sync_missing;
        logic   two_sfu;
        logic   ei_early;
        logic   sfu_sync_missing;
        logic   tex_sync_missing;
        logic   delay_short;
        logic   reg_out_of_range;
        logic   program_end;
    } sih_result_t;

    typedef struct packed {
        logic [1:0] kind;
        cycle_t     cycle;
    } sih_entry_t;

    localparam int ENTRY_W = $bits(sih_entry_t);

    typedef struct packed {
        logic [BANKS-1:0]              en;
        logic [BANKS-1:0][BANK_AW-1:0] addr;
        sih_entry_t                    data;
    } sih_wr_t;

    typedef struct packed {
        cycle_t cycle_count;
        cycle_t last_ss_cycle;
        cycle_t last_sy_cycle;
        logic   seen_first;
        logic   prev_was_sfu;
        logic   input_ei_seen;
    } sih_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sih_instr_if.sv @@
`default_nettype none

interface sih_instr_if
    import sih_pkg::*;
();
    logic      valid;
    logic      ready;
    sih_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sih_result_if.sv @@
`default_nettype none

interface sih_result_if
    import sih_pkg::*;
();
    logic        valid;
    logic        ready;
    sih_result_t res;

    modport source (output valid, output res, input ready);
    modport sink (input valid, input res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sih_cfg_if.sv @@
`default_nettype none

interface sih_cfg_if
    import sih_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] reg_limit;

    modport source (output valid, output reg_limit, input ready);
    modport sink (input valid, input reg_limit, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sih_ram.sv @@
`default_nettype none

// one write port, one registered read port, write-first on a collision
module sih_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sih_scoreboard.sv @@
`default_nettype none

// Banked by low index bits so four consecutive destinations write together;
// each bank is copied once per source slot.
module sih_scoreboard
    import sih_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire reg_idx_t [NUM_SRC-1:0]     rd_idx,
    input  wire reg_idx_t [NUM_SRC-1:0]     cur_idx,
    input  wire sih_wr_t                    wr,
    output sih_entry_t    [NUM_SRC-1:0]     entry
);

    logic [NUM_SRC-1:0][BANKS-1:0][ENTRY_W-1:0] row;
    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;

    for (genvar p = 0; p < NUM_SRC; p++)
    begin : g_port
        for (genvar b = 0; b < BANKS; b++)
        begin : g_bank
            sih_ram #(
                .DEPTH (BANK_DEPTH),
                .WIDTH (ENTRY_W)
            ) u_ram (
                .clk   (clk),
                .we    (wr.en[b]),
                .waddr (wr.addr[b]),
                .wdata (wr.data),
                .re    (rd_en),
                .raddr (rd_idx[p][REG_IDX_W-1:BANK_W]),
                .rdata (row[p][b])
            );
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int b = 0; b < BANKS; b++)
        begin
            if (wr.en[b])
            begin
                valid_next[{wr.addr[b], BANK_W'(b)}] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_SRC; p++)
        begin
            entry[p] = sih_entry_t'(row[p][cur_idx[p][BANK_W-1:0]]);
            if (!valid_reg[cur_idx[p]])
            begin
                entry[p].kind = WK_NONE;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sih_check.sv @@
`default_nettype none

module sih_check
    import sih_pkg::*;
(
    input  wire sih_item_t              item,
    input  wire logic [LIMIT_W-1:0]     reg_limit,
    input  wire sih_state_t             state,
    input  wire sih_entry_t [NUM_SRC-1:0] entry,
    output sih_result_t                 res,
    output sih_state_t                  state_next,
    output sih_wr_t                     wr
);

    function automatic cycle_t slots_needed(input logic [1:0] wk, input logic [2:0] kind,
                                            input int slot);
        cycle_t n;
        if ((wk == WK_SFU) || (wk == WK_TEX))
        begin
            n = '0;
        end
        else if ((wk == WK_ALU) && ((kind == KIND_SFU) || (kind == KIND_TEX)))
        begin
            n = CYCLE_BITS'(SLOTS_LONG);
        end
        else if ((kind == KIND_ALU3) && (slot == SLOT_SHORT_SRC))
        begin
            n = CYCLE_BITS'(SLOTS_SHORT);
        end
        else
        begin
            n = CYCLE_BITS'(SLOTS_STD);
        end
        return n;
    endfunction

    reg_idx_t [NUM_SRC-1:0] src;
    cycle_t                 cyc;
    cycle_t                 ss_cyc;
    cycle_t                 sy_cyc;
    cycle_t                 need;
    logic [DST_CNT_W-1:0]   dcnt;
    logic                   dst_ok;
    logic                   src_on;
    logic                   has_writer;
    logic [BANK_W-1:0]      off;
    logic [LIMIT_W-1:0]     didx;

    assign src = {item.src_c, item.src_b, item.src_a};

    always_comb
    begin
        cyc = state.cycle_count;
        if (item.kind != KIND_TEX)
        begin
            cyc = state.cycle_count + CYCLE_BITS'(1);
        end
        ss_cyc = state.last_ss_cycle;
        if ((item.kind != KIND_FLOW) && (item.kind <= KIND_SFU) && item.sync_ss)
        begin
            ss_cyc = cyc;
        end
        sy_cyc = item.sync_sy ? cyc : state.last_sy_cycle;

        state_next.cycle_count   = cyc;
        state_next.last_ss_cycle = ss_cyc;
        state_next.last_sy_cycle = sy_cyc;
        state_next.seen_first    = 1'b1;
        state_next.prev_was_sfu  = (item.kind == KIND_SFU);
        state_next.input_ei_seen = item.is_varying ? item.end_input : state.input_ei_seen;

        res = '0;
        res.cycle_now   = cyc;
        res.program_end = item.is_end;
        if (state.seen_first)
        begin
            res.two_sfu = state.prev_was_sfu && (item.kind == KIND_SFU);
        end
        else
        begin
            res.first_sync_missing = !(item.sync_ss && item.sync_sy);
        end
        res.ei_early = item.is_varying && state.input_ei_seen;

        need = '0;
        for (int k = 0; k < NUM_SRC; k++)
        begin
            src_on = item.src_mask[k] && !item.is_end;
            has_writer = src_on && (entry[k].kind != WK_NONE);
            if (src_on && ({1'b0, src[k]} >= reg_limit))
            begin
                res.reg_out_of_range = 1'b1;
            end
            if (has_writer && (entry[k].kind == WK_SFU) && !(ss_cyc > entry[k].cycle))
            begin
                res.sfu_sync_missing = 1'b1;
            end
            if (has_writer && (entry[k].kind == WK_TEX) && !(sy_cyc > entry[k].cycle))
            begin
                res.tex_sync_missing = 1'b1;
            end
            need = entry[k].cycle + slots_needed(entry[k].kind, item.kind, k);
            if (has_writer && (cyc < need))
            begin
                res.delay_short = 1'b1;
            end
        end

        dcnt = (item.dst_count > DST_CNT_W'(MAX_DST)) ? DST_CNT_W'(MAX_DST) : item.dst_count;
        dst_ok = !item.is_end && (item.kind != KIND_FLOW) && (item.kind <= KIND_TEX);

        wr.data.cycle = cyc;
        case (item.kind)
            KIND_SFU: wr.data.kind = WK_SFU;
            KIND_TEX: wr.data.kind = WK_TEX;
            default:  wr.data.kind = WK_ALU;
        endcase

        for (int b = 0; b < BANKS; b++)
        begin
            off = BANK_W'(b) - item.dst_base[BANK_W-1:0];
            didx = {1'b0, item.dst_base} + LIMIT_W'(off);
            wr.en[b] = dst_ok && (DST_CNT_W'(off) < dcnt) && (didx < LIMIT_W'(NUM_REGS));
            wr.addr[b] = didx[REG_IDX_W-1:BANK_W];
            if (dst_ok && (DST_CNT_W'(off) < dcnt) && (didx >= reg_limit))
            begin
                res.reg_out_of_range = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/shader_issue_hazard_checker.sv @@
// An accepted instruction is registered in s1_item_reg, its result in out_res_reg.
// Throughput: one instruction per cycle while result.ready is high; the scoreboard
// is four write-first RAM banks, copied per source slot, so reads and up to four
// writes complete each cycle. Asynchronous reset at once clears the issue state and
// the per-register valid bits; reg_limit returns to 256. No clearing pass is needed.
`default_nettype none

`include "shader_issue_hazard_checker_macros.svh"

module shader_issue_hazard_checker
    import sih_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    sih_cfg_if.sink     cfg,
    sih_instr_if.sink   instr,
    sih_result_if.source result
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    sih_item_t          s1_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    sih_result_t        out_res_reg;
    sih_state_t         state_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic                   s1_fire;
    logic                   instr_accept;
    sih_result_t            chk_res;
    sih_state_t             chk_state;
    sih_wr_t                chk_wr;
    sih_wr_t                sb_wr;
    sih_entry_t [NUM_SRC-1:0] sb_entry;

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready  = !s1_valid_reg || s1_fire;
    assign instr_accept = instr.valid && instr.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.res   = out_res_reg;

    assign s1_valid_next  = instr_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_comb
    begin
        sb_wr    = chk_wr;
        sb_wr.en = chk_wr.en & {BANKS{s1_fire}};
    end

    sih_scoreboard u_scoreboard (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (instr_accept),
        .rd_idx  ({instr.item.src_c, instr.item.src_b, instr.item.src_a}),
        .cur_idx ({s1_item_reg.src_c, s1_item_reg.src_b, s1_item_reg.src_a}),
        .wr      (sb_wr),
        .entry   (sb_entry)
    );

    sih_check u_check (
        .item       (s1_item_reg),
        .reg_limit  (limit_reg),
        .state      (state_reg),
        .entry      (sb_entry),
        .res        (chk_res),
        .state_next (chk_state),
        .wr         (chk_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                state_reg <= chk_state;
            end
            if (cfg.valid)
            begin
                limit_reg <= cfg.reg_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_accept)
        begin
            s1_item_reg <= instr.item;
        end
        if (s1_fire)
        begin
            out_res_reg <= chk_res;
        end
    end

    `SIH_ASSERT_NXT(a_fire_gives_result, clk, rst_n, s1_fire, out_valid_reg)
    `SIH_ASSERT_NEVER(a_no_overrun, clk, rst_n, instr_accept && s1_valid_reg && !s1_fire)
    `SIH_ASSERT_NXT(a_count_holds, clk, rst_n, !s1_fire, $stable(state_reg.cycle_count))
    `SIH_ASSERT_NXT(a_count_steps, clk, rst_n, s1_fire && (s1_item_reg.kind != KIND_TEX),
        state_reg.cycle_count == ($past(state_reg.cycle_count) + CYCLE_BITS'(1)))

endmodule

`default_nettype wire

@@ tb/sih_issue_compare.sv @@
`timescale 1ns / 100ps

module sih_issue_compare
    import sih_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sih_cfg_if    cfg,
    sih_instr_if  instr,
    sih_result_if result,
    output int    mismatches,
    output int    reports_pending
);

    logic [1:0]         sb_kind [NUM_REGS];
    cycle_t             sb_cycle [NUM_REGS];
    cycle_t             issue_cycle;
    cycle_t             ss_cycle;
    cycle_t             sy_cycle;
    logic               seen_first;
    logic               prev_sfu;
    logic               ei_seen;
    logic [LIMIT_W-1:0] reg_limit_now;

    sih_result_t expected_reports[$];

    function automatic int unsigned slots_for(input logic [1:0] wk, input logic [2:0] kind,
                                              input int unsigned slot);
        if (wk == WK_SFU || wk == WK_TEX)
            return 0;
        if (wk == WK_ALU && (kind == KIND_SFU || kind == KIND_TEX))
            return SLOTS_LONG;
        if (kind == KIND_ALU3 && slot == SLOT_SHORT_SRC)
            return SLOTS_SHORT;
        return SLOTS_STD;
    endfunction

    // advances the scoreboard by one instruction and returns the report it should cause
    function automatic sih_result_t predict_issue_report(input sih_item_t it);
        sih_result_t r;
        reg_idx_t    src [NUM_SRC];
        int unsigned dst_n;
        int unsigned idx;
        logic [1:0]  wk;
        cycle_t      need;
        r = '0;
        src[0] = it.src_a;
        src[1] = it.src_b;
        src[2] = it.src_c;
        dst_n = (it.dst_count > MAX_DST) ? MAX_DST : it.dst_count;

        if (seen_first)
            r.two_sfu = prev_sfu && it.kind == KIND_SFU;
        else
            r.first_sync_missing = !(it.sync_ss && it.sync_sy);

        if (it.kind != KIND_TEX)
            issue_cycle = issue_cycle + 1'b1;

        if (it.is_varying)
        begin
            r.ei_early = ei_seen;
            ei_seen = it.end_input;
        end

        if (it.kind != KIND_FLOW && it.kind <= KIND_SFU && it.sync_ss)
            ss_cycle = issue_cycle;
        if (it.sync_sy)
            sy_cycle = issue_cycle;

        if (!it.is_end)
        begin
            for (int unsigned k = 0; k < NUM_SRC; k++)
            begin
                if (!it.src_mask[k])
                    continue;
                idx = src[k];
                if (idx >= reg_limit_now)
                    r.reg_out_of_range = 1'b1;
                wk = sb_kind[idx];
                if (wk == WK_NONE)
                    continue;
                if (wk == WK_SFU && !(ss_cycle > sb_cycle[idx]))
                    r.sfu_sync_missing = 1'b1;
                else if (wk == WK_TEX && !(sy_cycle > sb_cycle[idx]))
                    r.tex_sync_missing = 1'b1;
                need = sb_cycle[idx] + cycle_t'(slots_for(wk, it.kind, k));
                if (issue_cycle < need)
                    r.delay_short = 1'b1;
            end

            if (it.kind != KIND_FLOW && it.kind <= KIND_TEX)
            begin
                wk = (it.kind == KIND_SFU) ? WK_SFU : (it.kind == KIND_TEX) ? WK_TEX : WK_ALU;
                for (int unsigned k = 0; k < dst_n; k++)
                begin
                    idx = int'(it.dst_base) + k;
                    if (idx >= reg_limit_now)
                        r.reg_out_of_range = 1'b1;
                    if (idx < NUM_REGS)
                    begin
                        sb_kind[idx] = wk;
                        sb_cycle[idx] = issue_cycle;
                    end
                end
            end
        end

        seen_first = 1'b1;
        prev_sfu = (it.kind == KIND_SFU);

        r.cycle_now = issue_cycle;
        r.program_end = it.is_end;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CYCLE_BITS-1:0] exp_v,
                               input logic [CYCLE_BITS-1:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        end
    endtask

    task automatic compare_report(input sih_result_t exp_r, input sih_result_t got);
        check_field("cycle_now", exp_r.cycle_now, got.cycle_now);
        check_field("first_sync_missing", exp_r.first_sync_missing, got.first_sync_missing);
        check_field("two_sfu", exp_r.two_sfu, got.two_sfu);
        check_field("ei_early", exp_r.ei_early, got.ei_early);
        check_field("sfu_sync_missing", exp_r.sfu_sync_missing, got.sfu_sync_missing);
        check_field("tex_sync_missing", exp_r.tex_sync_missing, got.tex_sync_missing);
        check_field("delay_short", exp_r.delay_short, got.delay_short);
        check_field("reg_out_of_range", exp_r.reg_out_of_range, got.reg_out_of_range);
        check_field("program_end", exp_r.program_end, got.program_end);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                sb_kind[i] = WK_NONE;
                sb_cycle[i] = '0;
            end
            issue_cycle = '0;
            ss_cycle = '0;
            sy_cycle = '0;
            seen_first = 1'b0;
            prev_sfu = 1'b0;
            ei_seen = 1'b0;
            reg_limit_now = LIMIT_RESET;
            expected_reports.delete();
            mismatches = 0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                reg_limit_now = cfg.reg_limit;
            if (instr.valid && instr.ready)
                expected_reports.push_back(predict_issue_report(instr.item));
            if (result.valid && result.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected report, expected none, actual %0h",
                             $time, result.res);
                end
                else
                    compare_report(expected_reports.pop_front(), result.res);
            end
            reports_pending <= expected_reports.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import sih_pkg::*;

    localparam logic [2:0] KIND_ALU1  = 3'd1;
    localparam logic [2:0] KIND_ALU2  = 3'd2;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 346;
    localparam int HOT_SPAN     = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;

    logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
    reg_idx_t           hot_base = '0;

    int mismatches;
    int reports_pending;

    sih_cfg_if    cfg();
    sih_instr_if  instr();
    sih_result_if result();

    shader_issue_hazard_checker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .instr  (instr),
        .result (result)
    );

    sih_issue_compare scoreboard_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .instr           (instr),
        .result          (result),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result back-pressure
    always
    begin
        @(posedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            result.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        result.ready <= 1'b1;
    end

    function automatic reg_idx_t hot_idx();
        return hot_base + reg_idx_t'($urandom_range(0, HOT_SPAN - 1));
    endfunction

    function automatic sih_item_t random_instr();
        sih_item_t   it;
        logic [63:0] raw;
        int unsigned pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(sih_item_t)-1:0];
        if ($urandom_range(0, 9) == 0)
            return it;

        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.kind = 3'($urandom_range(KIND_ALU1, KIND_ALU3));
        else if (pick < 60)
            it.kind = KIND_SFU;
        else if (pick < 75)
            it.kind = KIND_TEX;
        else if (pick < 88)
            it.kind = KIND_FLOW;
        else
            it.kind = 3'($urandom_range(KIND_RSVD6, KIND_RSVD7));

        it.is_end     = ($urandom_range(0, 39) == 0);
        it.is_varying = ($urandom_range(0, 7) == 0);
        it.sync_ss    = ($urandom_range(0, 3) == 0);
        it.sync_sy    = ($urandom_range(0, 3) == 0);
        it.src_a      = hot_idx();
        it.src_b      = hot_idx();
        it.src_c      = hot_idx();
        it.dst_base   = hot_idx();
        if ($urandom_range(0, 5) == 0)
            it.dst_count = DST_CNT_W'($urandom_range(0, 7));
        else
            it.dst_count = DST_CNT_W'($urandom_range(1, MAX_DST));
        return it;
    endfunction

    task automatic issue(input sih_item_t it);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            instr.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        instr.valid <= 1'b1;
        instr.item  <= it;
        @(posedge clk);
        while (!instr.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        instr.valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg.valid     <= 1'b1;
        cfg.reg_limit <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cur_limit = value;
    endtask

    initial
    begin
        sih_item_t          it;
        logic [LIMIT_W-1:0] lim;

        instr.valid   <= 1'b0;
        instr.item    <= '0;
        cfg.valid     <= 1'b0;
        cfg.reg_limit <= LIMIT_RESET;
        result.ready  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first item without sy
        it = '0; it.kind = KIND_ALU1; it.sync_ss = 1'b1; it.dst_count = 3'd4;
        issue(it);
        // alu result read too soon, short slot on src c
        it = '0; it.kind = KIND_ALU3; it.src_mask = 3'b101; it.src_a = 8'd1;
        it.dst_base = 8'd8; it.dst_count = 3'd1;
        issue(it);
        it = '0; it.kind = KIND_SFU; it.src_mask = 3'b001; it.src_a = 8'd2;
        it.dst_base = 8'd16; it.dst_count = 3'd1;
        issue(it);
        // back to back sfu
        it = '0; it.kind = KIND_SFU; it.dst_base = 8'd17; it.dst_count = 3'd1;
        issue(it);
        it = '0; it.kind = KIND_ALU2; it.src_mask = 3'b001; it.src_a = 8'd16;
        issue(it);
        it = '0; it.kind = KIND_ALU1; it.sync_ss = 1'b1; it.src_mask = 3'b001; it.src_a = 8'd17;
        issue(it);
        it = '0; it.kind = KIND_TEX; it.dst_base = 8'd20; it.dst_count = 3'd4;
        issue(it);
        it = '0; it.kind = KIND_ALU1; it.src_mask = 3'b010; it.src_b = 8'd21;
        issue(it);
        // flow with sy: destinations ignored
        it = '0; it.kind = KIND_FLOW; it.sync_sy = 1'b1; it.src_mask = 3'b001; it.src_a = 8'd22;
        it.dst_base = 8'd30; it.dst_count = 3'd4;
        issue(it);
        it = '0; it.kind = KIND_ALU1; it.is_varying = 1'b1; it.end_input = 1'b1;
        issue(it);
        it = '0; it.kind = KIND_ALU1; it.is_varying = 1'b1;
        issue(it);
        // end instruction: no reads, no writes
        it = '0; it.kind = KIND_ALU1; it.is_end = 1'b1; it.src_mask = 3'b111;
        it.dst_base = 8'd40; it.dst_count = 3'd4;
        issue(it);
        it = '0; it.kind = KIND_ALU1; it.src_mask = 3'b001; it.src_a = 8'd40;
        issue(it);
        // destinations run past the scoreboard, count clamped
        it = '0; it.kind = KIND_ALU2; it.dst_base = 8'd254; it.dst_count = 3'd7;
        issue(it);
        it = '0; it.kind = KIND_ALU3; it.src_mask = 3'b111;
        it.src_a = 8'd255; it.src_b = 8'd255; it.src_c = 8'd255;
        issue(it);
        it = '0; it.kind = KIND_RSVD6; it.src_mask = 3'b001; it.dst_count = 3'd3;
        issue(it);
        it = '0; it.kind = KIND_RSVD7;
        issue(it);
        it = '1;
        issue(it);
        it = '0;
        issue(it);
        it = '0; it.kind = KIND_TEX; it.sync_sy = 1'b1; it.src_mask = 3'b001; it.src_a = 8'd8;
        issue(it);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1: lim = '0;
                    2: lim = LIMIT_W'(NUM_REGS - 1);
                    3: lim = LIMIT_W'($urandom_range(1, NUM_REGS - 2));
                    default: lim = LIMIT_RESET;
                endcase
                write_limit(lim);
            end
            calm = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                begin
                    if (cur_limit >= 8 && $urandom_range(0, 2) == 0)
                        hot_base = reg_idx_t'(cur_limit - 8);
                    else
                        hot_base = reg_idx_t'($urandom_range(0, NUM_REGS - 1));
                end
                issue(random_instr());
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ shader_issue_hazard_checker.f @@
+incdir+hw/rtl
hw/rtl/sih_pkg.sv
hw/rtl/sih_instr_if.sv
hw/rtl/sih_result_if.sv
hw/rtl/sih_cfg_if.sv
hw/rtl/sih_ram.sv
hw/rtl/sih_scoreboard.sv
hw/rtl/sih_check.sv
hw/rtl/shader_issue_hazard_checker.sv
tb/sih_issue_compare.sv
tb/testbench.sv
